>>> hdl/cwg_pkg.sv
package cwg_pkg;

    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned LEFT_W  = 8;
    localparam int unsigned WDAY_W  = 3;

    localparam logic [YEAR_W-1:0]  EPOCH_YEAR = 12'd1970;
    localparam logic [12:0]        YEAR_BIAS  = 13'd2462;
    localparam logic [YEAR_W-1:0]  EPOCH_WDAY = 12'd3;
    localparam logic [WDAY_W-1:0]  LAST_SLOT  = 3'd6;
    localparam logic [WDAY_W-1:0]  WEEK_WRAP  = 3'd7;
    localparam logic [MONTH_W-1:0] JANUARY    = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY   = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER   = 4'd12;

    localparam logic [1:0] REG_START_YEAR  = 2'd0;
    localparam logic [1:0] REG_START_MONTH = 2'd1;
    localparam logic [1:0] REG_MONTH_COUNT = 2'd2;

    localparam logic [2:0] OFFS_COMMON [12] = '{3'd0, 3'd3, 3'd3, 3'd6, 3'd1, 3'd4,
                                                3'd6, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5};
    localparam logic [2:0] OFFS_LEAP   [12] = '{3'd0, 3'd3, 3'd4, 3'd0, 3'd2, 3'd5,
                                                3'd0, 3'd3, 3'd6, 3'd1, 3'd4, 3'd6};

    typedef enum logic [1:0] {
        S_IDLE,
        S_WDAY,
        S_EMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              done;
        logic [WDAY_W-1:0] wday;
    } t_wd_rsp;

    function automatic logic month_ok(input logic [MONTH_W-1:0] m);
        return (m >= JANUARY) && (m <= DECEMBER);
    endfunction

    function automatic logic [2:0] month_offset(input logic leap,
                                                input logic [MONTH_W-1:0] m);
        logic [3:0] idx;
        idx = month_ok(m) ? (m - JANUARY) : 4'd0;
        return leap ? OFFS_LEAP[idx] : OFFS_COMMON[idx];
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [YEAR_W-1:0] y,
                                                    input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
            FEBRUARY:                d = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

>>> hdl/cwg_weekday.sv
module cwg_weekday
    import cwg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    output t_wd_rsp            o_rsp
);

    logic               r_busy;
    logic [2:0]         r_step;
    logic [YEAR_W-1:0]  r_acc;
    logic [YEAR_W-1:0]  r_year;
    logic [MONTH_W-1:0] r_month;
    logic               r_done;
    logic [WDAY_W-1:0]  r_wday;

    logic [12:0]        base_sum;
    logic [YEAR_W-1:0]  n_acc;

    // one adder, operands picked by step: year term, month term, then octal folds
    always_comb begin
        base_sum = {1'b0, r_year} + {1'b0, (r_year - 12'd1) >> 2} - YEAR_BIAS;
        case (r_step)
            3'd0:    n_acc = (r_year > EPOCH_YEAR) ? base_sum[YEAR_W-1:0] : '0;
            3'd1:    n_acc = r_acc + EPOCH_WDAY
                           + {9'd0, month_offset(r_year[1:0] == 2'b00, r_month)};
            default: n_acc = {9'd0, r_acc[11:9]} + {9'd0, r_acc[8:6]}
                           + {9'd0, r_acc[5:3]} + {9'd0, r_acc[2:0]};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_year  <= i_year;
            r_month <= i_month;
        end else if (r_busy) begin
            r_acc <= n_acc;
            if (r_step == 3'd4) begin
                r_wday <= (n_acc[2:0] == WEEK_WRAP) ? '0 : n_acc[2:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.wday = r_wday;

endmodule

>>> hdl/calendar_week_generator_unit.sv
// Monday-first month calendar, one week per input transfer. A transfer on the slave side
// (tdata bit 0 = restart) yields seven slot transfers, Monday to Sunday, the last with tlast;
// when no months remain it yields a single transfer with tuser and tlast set. A week that
// begins on day 1 of a month first runs the weekday unit (year term, month offset, three octal
// folds for mod 7) and then picks up its result; a week that continues a month goes straight to
// its slots, and a done request to its single done transfer. Each slot is one cycle of the date
// stepper, and output stalls stretch this. Configuration writes take effect only at a request
// with restart set.
module calendar_week_generator_unit
    import cwg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // restart
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // slot_valid, date_year, date_month, date_day,
                                          // slot_index
    output logic        o_m_axis_tlast,
    output logic        o_m_axis_tuser    // calendar_done
);

    logic [YEAR_W-1:0]  r_cfg_year;
    logic [MONTH_W-1:0] r_cfg_month;
    logic [LEFT_W-1:0]  r_cfg_count;

    t_state             r_state, n_state;
    logic [YEAR_W-1:0]  r_year, n_year;
    logic [MONTH_W-1:0] r_month, n_month;
    logic [DAY_W-1:0]   r_day, n_day;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic [WDAY_W-1:0]  r_pos, n_pos;
    logic [WDAY_W-1:0]  r_slot, n_slot;

    logic               r_m_tvalid, n_m_tvalid;
    logic [31:0]        r_m_tdata, n_m_tdata;
    logic               r_m_tlast, n_m_tlast;
    logic               r_m_tuser, n_m_tuser;

    logic               s_fire;
    logic               can_load;
    logic               restart;
    logic [YEAR_W-1:0]  e_year;
    logic [MONTH_W-1:0] e_month;
    logic [DAY_W-1:0]   e_day;
    logic [LEFT_W-1:0]  e_left;
    logic               wd_start;
    t_wd_rsp            wd_rsp;
    logic               slot_ok;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign can_load        = !r_m_tvalid || i_m_axis_tready;
    assign restart         = i_s_axis_tdata[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_year  <= 12'd2020;
            r_cfg_month <= JANUARY;
            r_cfg_count <= 8'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_START_YEAR:  r_cfg_year  <= i_cfg_data;
                REG_START_MONTH: r_cfg_month <= i_cfg_data[MONTH_W-1:0];
                REG_MONTH_COUNT: r_cfg_count <= i_cfg_data[LEFT_W-1:0];
                default: ;
            endcase
        end
    end

    // state after an optional restart
    always_comb begin
        if (restart) begin
            e_year  = r_cfg_year;
            e_month = month_ok(r_cfg_month) ? r_cfg_month : JANUARY;
            e_day   = 5'd1;
            e_left  = r_cfg_count;
        end else begin
            e_year  = r_year;
            e_month = r_month;
            e_day   = r_day;
            e_left  = r_left;
        end
    end

    cwg_weekday u_weekday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (wd_start),
        .i_year  (e_year),
        .i_month (e_month),
        .o_rsp   (wd_rsp)
    );

    always_comb begin
        n_state    = r_state;
        n_year     = r_year;
        n_month    = r_month;
        n_day      = r_day;
        n_left     = r_left;
        n_pos      = r_pos;
        n_slot     = r_slot;
        n_m_tvalid = r_m_tvalid && !i_m_axis_tready;
        n_m_tdata  = r_m_tdata;
        n_m_tlast  = r_m_tlast;
        n_m_tuser  = r_m_tuser;
        wd_start   = 1'b0;
        slot_ok    = (r_slot >= r_pos) && (r_left != '0);
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_year  = e_year;
                    n_month = e_month;
                    n_day   = e_day;
                    n_left  = e_left;
                    n_pos   = '0;
                    n_slot  = '0;
                    if (e_left == '0) begin
                        n_state = S_DONE;
                    end else if (e_day == 5'd1) begin
                        wd_start = 1'b1;
                        n_state  = S_WDAY;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_WDAY: begin
                if (wd_rsp.done) begin
                    n_pos   = wd_rsp.wday;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (can_load) begin
                    n_m_tvalid = 1'b1;
                    n_m_tlast  = (r_slot == LAST_SLOT);
                    n_m_tuser  = 1'b0;
                    if (slot_ok) begin
                        n_m_tdata = {7'd0, r_slot, r_day, r_month, r_year, 1'b1};
                        if (r_day == month_days(r_year, r_month)) begin
                            n_day  = 5'd1;
                            n_left = r_left - 8'd1;
                            if (r_month >= DECEMBER) begin
                                n_month = JANUARY;
                                n_year  = r_year + 12'd1;
                            end else begin
                                n_month = r_month + 4'd1;
                            end
                        end else begin
                            n_day = r_day + 5'd1;
                        end
                    end else begin
                        n_m_tdata = {7'd0, r_slot, 22'd0};
                    end
                    if (r_slot == LAST_SLOT) begin
                        n_state = S_IDLE;
                    end else begin
                        n_slot = r_slot + 3'd1;
                    end
                end
            end
            S_DONE: begin
                if (can_load) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = '0;
                    n_m_tlast  = 1'b1;
                    n_m_tuser  = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_year     <= 12'd2020;
            r_month    <= JANUARY;
            r_day      <= 5'd1;
            r_left     <= 8'd1;
            r_pos      <= '0;
            r_slot     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_year     <= n_year;
            r_month    <= n_month;
            r_day      <= n_day;
            r_left     <= n_left;
            r_pos      <= n_pos;
            r_slot     <= n_slot;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_tdata <= n_m_tdata;
        r_m_tlast <= n_m_tlast;
        r_m_tuser <= n_m_tuser;
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tlast  = r_m_tlast;
    assign o_m_axis_tuser  = r_m_tuser;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("done transfer without tlast");

    a_wday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wd_rsp.done |-> wd_rsp.wday != WEEK_WRAP)
        else $error("weekday out of range");

    a_date_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |->
            month_ok(o_m_axis_tdata[16:13]) && (o_m_axis_tdata[21:17] != 5'd0))
        else $error("valid slot with bad date");

    a_day_in_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> (r_day <= month_days(r_year, r_month)) && month_ok(r_month))
        else $error("day counter past month end");

endmodule
